// ----- rtl/ipsr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the incremental PID speed regulator.
// No dependencies; every other rtl file imports this package.
package ipsr_pkg;

    localparam int NOW_W      = 32;
    localparam int PER_W      = 16;
    localparam int TGT_W      = 15;
    localparam int DRV_W      = 9;
    localparam int ERR_W      = 16;
    localparam int RATE_W     = 8;
    localparam int INTV_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SPD_W      = 15;

    // Shared divider: 25-bit dividend covers the PID numerator magnitude
    localparam int DIV_NUM_W  = 25;
    localparam int DIV_DEN_W  = 16;
    localparam int GDIV_W     = 7;
    localparam int PID_W      = 27;
    localparam int PROD_W     = PER_W + RATE_W;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd1;

    localparam logic [INTV_W-1:0] INTERVAL_RESET = 16'd640;
    localparam logic [RATE_W-1:0] RATE_RESET     = 8'd1;
    localparam logic [DRV_W-1:0]  DRIVE_RESET    = 9'd70;
    localparam logic [DRV_W-1:0]  DRIVE_MAX      = 9'd300;
    localparam logic [SPD_W-1:0]  SPEED_SAT      = 15'h7fff;
    localparam logic [DIV_NUM_W-1:0] SPEED_NUMER = 25'd62832;
    localparam logic [TGT_W-1:0]  GAIN_KNEE      = 15'd200;
    localparam logic [GDIV_W-1:0] GAIN_BASE      = 7'd10;
    localparam logic [GDIV_W-1:0] GAIN_TOP       = 7'd100;

    localparam logic signed [PID_W-1:0] K_E  = 27'sd245;
    localparam logic signed [PID_W-1:0] K_E1 = 27'sd350;
    localparam logic signed [PID_W-1:0] K_E2 = 27'sd125;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b000_0001,
        S_CHECK   = 7'b000_0010,
        S_SPD_DIV = 7'b000_0100,
        S_ERR     = 7'b000_1000,
        S_PID     = 7'b001_0000,
        S_PID_DIV = 7'b010_0000,
        S_DRIVE   = 7'b100_0000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic time_load;
        logic spd_start;
        logic err_calc;
        logic pid_start;
        logic drive_upd;
    } cmd_t;

    typedef struct packed {
        logic advancing;
        logic too_early;
        logic period_zero;
        logic div_done;
        logic out_free;
    } status_t;

    // 10 + ((200 - t) * 90) / 200 below the knee, else 10.
    // x/200*90 = ((x*9) >> 2) / 5; the /5 is a reciprocal multiply (205/1024),
    // exact for the values below 451 that occur here.
    function automatic logic [GDIV_W-1:0] gain_divisor(input logic [TGT_W-1:0] t);
        logic [7:0]  diff;
        logic [10:0] x;
        logic [16:0] y;
        diff = 8'(GAIN_KNEE - t);
        x    = 11'(diff) * 11'd9;
        y    = 17'(x[10:2]) * 17'd205;
        if (t < GAIN_KNEE)
        begin
            gain_divisor = GAIN_BASE + 7'(y[16:10]);
        end
        else
        begin
            gain_divisor = GAIN_BASE;
        end
    endfunction

endpackage

// ----- rtl/ipsr_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ipsr_pkg for operand widths.
module ipsr_div
    import ipsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_NUM_W-1:0] quo,
    output logic                 busy,
    output logic                 done
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   trial;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        if (!trial[DIV_DEN_W])
        begin
            rem_next = trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign busy = busy_reg;
    assign done = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

// ----- rtl/ipsr_dp.sv -----
`timescale 1ns / 1ps
// Datapath: input, config and loop state registers, speed and PID arithmetic,
// output register. Depends on ipsr_pkg and ipsr_div.
module ipsr_dp
    import ipsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               sts,
    input  logic [NOW_W-1:0]      now_time,
    input  logic [PER_W-1:0]      period_count,
    input  logic [TGT_W-1:0]      target_speed,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DRV_W-1:0]      drive_level,
    output logic signed [ERR_W-1:0] speed_error
);

    logic [NOW_W-1:0]        now_reg;
    logic [PER_W-1:0]        period_reg;
    logic [TGT_W-1:0]        target_reg;
    logic [NOW_W-1:0]        last_time_reg;
    logic [INTV_W-1:0]       interval_reg;
    logic [RATE_W-1:0]       rate_reg;
    logic [DRV_W-1:0]        drive_reg, drive_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [ERR_W-1:0] e1_reg;
    logic signed [ERR_W-1:0] e2_reg;
    logic [GDIV_W-1:0]       gdiv_reg;
    logic                    neg_reg;
    logic                    out_valid_reg;
    logic [DRV_W-1:0]        drive_level_reg;
    logic signed [ERR_W-1:0] speed_error_reg;

    logic [NOW_W-1:0]        gap;
    logic [PROD_W-1:0]       prod;
    logic [SPD_W-1:0]        speed;
    logic [ERR_W:0]          diff;
    logic signed [PID_W-1:0] te, te1, te2, pid_num, pid_mag;
    logic [PID_W-1:0]        dq, acc, sum;
    logic                    div_start, div_busy, div_done;
    logic [DIV_NUM_W-1:0]    div_num, div_quo;
    logic [DIV_DEN_W-1:0]    div_den;

    // Time window check
    assign gap             = now_reg - last_time_reg;
    assign sts.advancing   = now_reg > last_time_reg;
    assign sts.too_early   = gap < NOW_W'(interval_reg);
    assign sts.period_zero = period_reg == '0;
    assign sts.div_done    = div_done;
    assign sts.out_free    = !out_valid_reg || out_ready;

    // Speed from the period quotient, saturated, then the error
    always_comb
    begin
        prod = PROD_W'(div_quo[PER_W-1:0]) * PROD_W'(rate_reg);
        if (sts.period_zero || (|prod[PROD_W-1:SPD_W+2]))
        begin
            speed = SPEED_SAT;
        end
        else
        begin
            speed = prod[SPD_W+1:2];
        end
        diff     = {2'b00, target_reg} - {2'b00, speed};
        err_next = diff[ERR_W-1:0];
    end

    // Incremental PID numerator, split into sign and magnitude for the divider
    always_comb
    begin
        te      = PID_W'(err_reg);
        te1     = PID_W'(e1_reg);
        te2     = PID_W'(e2_reg);
        pid_num = te * K_E - te1 * K_E1 + te2 * K_E2;
        pid_mag = pid_num[PID_W-1] ? -pid_num : pid_num;
    end

    assign div_start = cmd.spd_start || cmd.pid_start;
    assign div_num   = cmd.pid_start ? pid_mag[DIV_NUM_W-1:0] : SPEED_NUMER;
    assign div_den   = cmd.pid_start ? DIV_DEN_W'(gdiv_reg) : period_reg;

    ipsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .busy  (div_busy),
        .done  (div_done)
    );

    // Apply the signed delta and clamp the drive
    always_comb
    begin
        dq  = PID_W'(div_quo);
        acc = PID_W'(drive_reg);
        sum = neg_reg ? acc - dq : acc + dq;
        if (sum[PID_W-1])
        begin
            drive_next = '0;
        end
        else if (sum > PID_W'(DRIVE_MAX))
        begin
            drive_next = DRIVE_MAX;
        end
        else
        begin
            drive_next = sum[DRV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_RESET;
            rate_reg      <= RATE_RESET;
            last_time_reg <= '0;
            drive_reg     <= DRIVE_RESET;
            e1_reg        <= '0;
            e2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_INTERVAL)
            begin
                interval_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_RATE)
            begin
                rate_reg <= cfg_data[RATE_W-1:0];
            end
            if (cmd.time_load)
            begin
                last_time_reg <= now_reg;
            end
            // Age the error history as the numerator is consumed
            if (cmd.pid_start)
            begin
                e2_reg <= e1_reg;
                e1_reg <= err_reg;
            end
            if (cmd.drive_upd)
            begin
                drive_reg     <= drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            now_reg    <= now_time;
            period_reg <= period_count;
            target_reg <= target_speed;
        end
        if (cmd.err_calc)
        begin
            err_reg  <= err_next;
            gdiv_reg <= gain_divisor(target_reg);
        end
        if (cmd.pid_start)
        begin
            neg_reg <= pid_num[PID_W-1];
        end
        if (cmd.drive_upd)
        begin
            drive_level_reg <= drive_next;
            speed_error_reg <= err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_level = drive_level_reg;
    assign speed_error = speed_error_reg;

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        drive_reg <= DRIVE_MAX)
        else $error("drive accumulator out of range");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pid_start |-> (gdiv_reg >= GAIN_BASE) && (gdiv_reg <= GAIN_TOP))
        else $error("gain divisor out of range");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drive_upd |-> !out_valid_reg || out_ready)
        else $error("result word overwritten before it was taken");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drive_upd |-> !div_busy)
        else $error("drive updated while the divider was running");

endmodule

// ----- rtl/ipsr_ctrl.sv -----
`timescale 1ns / 1ps
// Control state machine: sequences time check, speed divide, PID divide
// and drive update. Depends on ipsr_pkg.
module ipsr_ctrl
    import ipsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (!sts.advancing)
                begin
                    // time went backwards or stood: reload and drop the word
                    cmd.time_load = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (sts.too_early)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.period_zero)
                begin
                    cmd.time_load = 1'b1;
                    state_next    = S_ERR;
                end
                else
                begin
                    cmd.time_load = 1'b1;
                    cmd.spd_start = 1'b1;
                    state_next    = S_SPD_DIV;
                end
            end
            S_SPD_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.err_calc = 1'b1;
                state_next   = S_PID;
            end
            S_PID:
            begin
                cmd.pid_start = 1'b1;
                state_next    = S_PID_DIV;
            end
            S_PID_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_DRIVE;
                end
            end
            S_DRIVE:
            begin
                // hold until the output slot is free
                if (sts.out_free)
                begin
                    cmd.drive_upd = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    a_ready_return: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(state_reg == S_CHECK) || $past(state_reg == S_DRIVE))
        else $error("controller returned to idle from an unexpected state");

endmodule

// ----- rtl/incremental_pid_speed_regulator.sv -----
`timescale 1ns / 1ps
// Incremental PID speed regulator. A stepping word passes the time check, the
// speed divide, the error step, the PID divide and the drive update; both divides
// use the shared restoring divider, and a zero period skips the speed divide.
// A word that takes no step goes back to idle straight from the time check.
// Reset: interval 640, rate factor 1, drive 70, error history and step time 0.
module incremental_pid_speed_regulator
    import ipsr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [NOW_W-1:0]        now_time,
    input  logic [PER_W-1:0]        period_count,
    input  logic [TGT_W-1:0]        target_speed,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DRV_W-1:0]        drive_level,
    output logic signed [ERR_W-1:0] speed_error,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cmd_t    cmd;
    status_t sts;

    // Config writes are registered straight into the config registers, always accepted
    assign cfg_ready = 1'b1;

    ipsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipsr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .now_time     (now_time),
        .period_count (period_count),
        .target_speed (target_speed),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_level  (drive_level),
        .speed_error  (speed_error)
    );

endmodule
